// ----- rtl/core/lqm_pkg.sv -----
// Shared types and constants of the linked queue manager.
`default_nettype none

package lqm_pkg;

   localparam int NODE_COUNT  = 64;
   localparam int QUEUE_COUNT = 4;
   localparam int NODE_W      = 6;
   localparam int QUEUE_W     = 2;
   localparam int COUNT_W     = 7;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;

   localparam logic [KIND_W-1:0] REQ_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_SIZE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_ISOLATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NODE_ISOLATED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_MEMBER   = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_CLOSE,
      S_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_APPEND_FIRST,
      OP_APPEND_LINK,
      OP_APPEND_CLOSE,
      OP_REMOVE_LINK,
      OP_REMOVE_LAST,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                load_status;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic is_append;
      logic is_remove;
      logic linked;
      logic nonempty;
      logic owner_match;
      logic multi;
      logic rsp_blocked;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/lqm_ctrl.sv -----
// Request sequencer of the linked queue manager.
`default_nettype none

module lqm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lqm_pkg::stat_type stat,
   output lqm_pkg::cmd_type      cmd
);
   import lqm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.op          = OP_NONE;
      cmd.load_status = 1'b0;
      cmd.status      = ST_OK;
      req_stall       = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.load_status = 1'b1;
            state_in        = S_RESPOND;
            if (stat.is_append) begin
               if (stat.linked) begin
                  cmd.status = ST_NOT_ISOLATED;
               end else if (stat.nonempty) begin
                  cmd.op   = OP_APPEND_LINK;
                  state_in = S_CLOSE;
               end else begin
                  cmd.op = OP_APPEND_FIRST;
               end
            end else if (stat.is_remove) begin
               if (!stat.nonempty) begin
                  cmd.status = ST_QUEUE_EMPTY;
               end else if (!stat.linked) begin
                  cmd.status = ST_NODE_ISOLATED;
               end else if (!stat.owner_match) begin
                  cmd.status = ST_NOT_MEMBER;
               end else if (stat.multi) begin
                  cmd.op = OP_REMOVE_LINK;
               end else begin
                  cmd.op = OP_REMOVE_LAST;
               end
            end
         end
         S_CLOSE: begin
            cmd.op   = OP_APPEND_CLOSE;
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            // hold until the output word has been taken
            if (!stat.rsp_blocked) begin
               cmd.op   = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/lqm_datapath.sv -----
// Link tables, queue registers and output word of the linked queue manager.
`default_nettype none

module lqm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lqm_pkg::KIND_W-1:0]    req_type,
   input  wire logic [lqm_pkg::QUEUE_W-1:0]   req_queue_id,
   input  wire logic [lqm_pkg::NODE_W-1:0]    req_node,
   input  wire lqm_pkg::cmd_type              cmd,
   output lqm_pkg::stat_type                  stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lqm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lqm_pkg::COUNT_W-1:0]        rsp_queue_length,
   output logic [lqm_pkg::NODE_W-1:0]         rsp_head_node,
   output logic                               rsp_head_valid
);
   import lqm_pkg::*;

   // link and owner tables
   logic [NODE_W-1:0]  next_mem  [NODE_COUNT];
   logic [NODE_W-1:0]  prev_mem  [NODE_COUNT];
   logic [QUEUE_W-1:0] owner_mem [NODE_COUNT];

   logic [NODE_W-1:0]  next_rd_ff;
   logic [NODE_W-1:0]  prev_rd_ff;
   logic [QUEUE_W-1:0] owner_rd_ff;

   logic [KIND_W-1:0]  kind_ff;
   logic [QUEUE_W-1:0] q_ff;
   logic [NODE_W-1:0]  n_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [QUEUE_COUNT-1:0][NODE_W-1:0]  head_ff;
   logic [QUEUE_COUNT-1:0][NODE_W-1:0]  head_in;
   logic [QUEUE_COUNT-1:0]              nonempty_ff;
   logic [QUEUE_COUNT-1:0]              nonempty_in;
   logic [QUEUE_COUNT-1:0][COUNT_W-1:0] count_ff;
   logic [QUEUE_COUNT-1:0][COUNT_W-1:0] count_in;
   logic [NODE_COUNT-1:0]               linked_ff;
   logic [NODE_COUNT-1:0]               linked_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_length_ff;
   logic [NODE_W-1:0]   rsp_head_ff;
   logic                rsp_head_valid_ff;

   logic                accept;
   logic [NODE_W-1:0]   prev_raddr;
   logic [NODE_W-1:0]   head_q;
   logic                next_we;
   logic [NODE_W-1:0]   next_waddr;
   logic [NODE_W-1:0]   next_wdata;
   logic                prev_we;
   logic [NODE_W-1:0]   prev_waddr;
   logic [NODE_W-1:0]   prev_wdata;
   logic                owner_we;

   assign accept     = (cmd.op == OP_ACCEPT);
   // an append needs the tail, which is the head's predecessor
   assign prev_raddr = (req_type == REQ_APPEND) ? head_ff[req_queue_id] : req_node;
   assign head_q     = head_ff[q_ff];
   assign owner_we   = (cmd.op == OP_APPEND_FIRST) || (cmd.op == OP_APPEND_CLOSE);

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_type;
         q_ff        <= req_queue_id;
         n_ff        <= req_node;
         next_rd_ff  <= next_mem[req_node];
         prev_rd_ff  <= prev_mem[prev_raddr];
         owner_rd_ff <= owner_mem[req_node];
      end
      if (cmd.load_status) begin
         status_ff <= cmd.status;
      end
   end

   always_comb begin
      next_we    = 1'b0;
      next_waddr = n_ff;
      next_wdata = n_ff;
      prev_we    = 1'b0;
      prev_waddr = n_ff;
      prev_wdata = n_ff;
      case (cmd.op)
         OP_APPEND_FIRST: begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         OP_APPEND_LINK: begin
            next_we    = 1'b1;
            next_wdata = head_q;
            prev_we    = 1'b1;
            prev_wdata = prev_rd_ff;
         end
         OP_APPEND_CLOSE: begin
            next_we    = 1'b1;
            next_waddr = prev_rd_ff;
            prev_we    = 1'b1;
            prev_waddr = head_q;
         end
         OP_REMOVE_LINK: begin
            // bridge the predecessor and successor over the removed node
            next_we    = 1'b1;
            next_waddr = prev_rd_ff;
            next_wdata = next_rd_ff;
            prev_we    = 1'b1;
            prev_waddr = next_rd_ff;
            prev_wdata = prev_rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (owner_we) begin
         owner_mem[n_ff] <= q_ff;
      end
   end

   always_comb begin
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      linked_in   = linked_ff;
      case (cmd.op)
         OP_APPEND_FIRST: begin
            head_in[q_ff]     = n_ff;
            nonempty_in[q_ff] = 1'b1;
            count_in[q_ff]    = count_ff[q_ff] + COUNT_W'(1);
            linked_in[n_ff]   = 1'b1;
         end
         OP_APPEND_CLOSE: begin
            count_in[q_ff]  = count_ff[q_ff] + COUNT_W'(1);
            linked_in[n_ff] = 1'b1;
         end
         OP_REMOVE_LINK: begin
            if (head_q == n_ff) begin
               head_in[q_ff] = next_rd_ff;
            end
            count_in[q_ff]  = count_ff[q_ff] - COUNT_W'(1);
            linked_in[n_ff] = 1'b0;
         end
         OP_REMOVE_LAST: begin
            head_in[q_ff]     = '0;
            nonempty_in[q_ff] = 1'b0;
            count_in[q_ff]    = '0;
            linked_in[n_ff]   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         count_ff    <= '0;
         linked_ff   <= '0;
      end else begin
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
         linked_ff   <= linked_in;
      end
   end

   always_comb begin
      stat.is_append   = (kind_ff == REQ_APPEND);
      stat.is_remove   = (kind_ff == REQ_REMOVE);
      stat.linked      = linked_ff[n_ff];
      stat.nonempty    = nonempty_ff[q_ff];
      stat.owner_match = (owner_rd_ff == q_ff);
      stat.multi       = (count_ff[q_ff] > COUNT_W'(1));
      stat.rsp_blocked = rsp_valid_ff && rsp_stall;
   end

   // output word: load only when free, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESPOND) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RESPOND) begin
         rsp_status_ff     <= status_ff;
         rsp_length_ff     <= count_ff[q_ff];
         rsp_head_ff       <= nonempty_ff[q_ff] ? head_q : '0;
         rsp_head_valid_ff <= nonempty_ff[q_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_queue_length = rsp_length_ff;
   assign rsp_head_node    = rsp_head_ff;
   assign rsp_head_valid   = rsp_head_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/linked_queue_manager.sv -----
// Linked queue manager: circular doubly linked queues over a shared node pool.
// Request channel (req_): req_type selects append, remove or size query of
// req_node on queue req_queue_id; a word is taken when req_valid is high and
// req_stall is low. Response channel (rsp_): one word per request with the
// status, the length and head of the target queue after the request.
// The response word is registered once the request has passed a check state
// and a respond state; an append to a non-empty queue also passes a close
// state for a second write pass over the link tables. The next request waits
// until the one before has loaded its response word, as set by the registered
// read of the link tables and their single write port. Membership and length
// come from owner tags and counters, so no request walks a queue.
// Reset empties every queue and isolates every node at once; the first request
// may follow in the next cycle.
// When the receiver stalls, the response word is held unchanged. The next
// request is still taken and worked on; its response waits until the held
// word has gone, and req_stall stays high until then.
`default_nettype none

module linked_queue_manager (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lqm_pkg::KIND_W-1:0]    req_type,
   input  wire logic [lqm_pkg::QUEUE_W-1:0]   req_queue_id,
   input  wire logic [lqm_pkg::NODE_W-1:0]    req_node,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [lqm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lqm_pkg::COUNT_W-1:0]        rsp_queue_length,
   output logic [lqm_pkg::NODE_W-1:0]         rsp_head_node,
   output logic                               rsp_head_valid
);
   import lqm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lqm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_queue_id     (req_queue_id),
      .req_node         (req_node),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_queue_length (rsp_queue_length),
      .rsp_head_node    (rsp_head_node),
      .rsp_head_valid   (rsp_head_valid)
   );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the linked queue manager against a shadow of the queues.
`timescale 1ns / 100ps

module testbench;
   import lqm_pkg::*;

   localparam logic [KIND_W-1:0] REQ_SPARE = 2'd3;  // unused code, answered as a size query
   localparam int HOLD_CYCLES = 300;
   localparam int CALM_TAIL   = 100;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  length;
      logic [NODE_W-1:0]   head;
      logic                head_valid;
   } rsp_word_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [QUEUE_W-1:0] qid;
      logic [NODE_W-1:0]  node;
      bit                 drain_first;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_type = REQ_SIZE;
   logic [QUEUE_W-1:0] req_queue_id = '0;
   logic [NODE_W-1:0] req_node = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_queue_length;
   logic [NODE_W-1:0] rsp_head_node;
   logic rsp_head_valid;

   linked_queue_manager dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_queue_id     (req_queue_id),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_queue_length (rsp_queue_length),
      .rsp_head_node    (rsp_head_node),
      .rsp_head_valid   (rsp_head_valid)
   );

   always #2 clock = ~clock;

   // Shadow of the link tables, updated as each request is taken.
   logic [NODE_W-1:0]  next_of [NODE_COUNT];
   logic [NODE_W-1:0]  prev_of [NODE_COUNT];
   logic               in_use  [NODE_COUNT];
   logic [QUEUE_W-1:0] owner_of [NODE_COUNT];
   logic [NODE_W-1:0]  head_of [QUEUE_COUNT];
   logic               filled  [QUEUE_COUNT];
   logic [COUNT_W-1:0] length_of [QUEUE_COUNT];

   // Membership as the stimulus planner sees it, one step ahead of the block.
   bit                 plan_linked [NODE_COUNT];
   int                 plan_owner [NODE_COUNT];
   int                 plan_len [QUEUE_COUNT];
   bit                 drain_next;

   req_item_type req_backlog[$];
   rsp_word_type pending_rsp[$];
   int        total_items;
   int        mismatches;
   int        words_seen;

   function automatic rsp_word_type apply_to_queues(logic [KIND_W-1:0] kind,
                                                    logic [QUEUE_W-1:0] q,
                                                    logic [NODE_W-1:0] n);
      rsp_word_type r;
      logic [NODE_W-1:0] h, t, nx, pv;
      r.status = ST_OK;
      if (kind == REQ_APPEND) begin
         if (in_use[n]) begin
            r.status = ST_NOT_ISOLATED;
         end else begin
            if (!filled[q]) begin
               head_of[q] = n;
               next_of[n] = n;
               prev_of[n] = n;
               filled[q] = 1'b1;
            end else begin
               h = head_of[q];
               t = prev_of[h];
               next_of[n] = h;
               prev_of[n] = t;
               next_of[t] = n;
               prev_of[h] = n;
            end
            in_use[n] = 1'b1;
            owner_of[n] = q;
            length_of[q] = length_of[q] + 1'b1;
         end
      end else if (kind == REQ_REMOVE) begin
         if (!filled[q]) begin
            r.status = ST_QUEUE_EMPTY;
         end else if (!in_use[n]) begin
            r.status = ST_NODE_ISOLATED;
         end else if (owner_of[n] != q) begin
            r.status = ST_NOT_MEMBER;
         end else begin
            if (length_of[q] > 1) begin
               nx = next_of[n];
               pv = prev_of[n];
               if (head_of[q] == n) begin
                  head_of[q] = nx;
               end
               next_of[pv] = nx;
               prev_of[nx] = pv;
               length_of[q] = length_of[q] - 1'b1;
            end else begin
               filled[q] = 1'b0;
               head_of[q] = '0;
               length_of[q] = '0;
            end
            in_use[n] = 1'b0;
            next_of[n] = '0;
            prev_of[n] = '0;
         end
      end
      r.length = length_of[q];
      r.head = filled[q] ? head_of[q] : '0;
      r.head_valid = filled[q];
      return r;
   endfunction

   function automatic void plan_request(int kind, int q, int n);
      req_item_type it;
      it.kind = KIND_W'(kind);
      it.qid = QUEUE_W'(q);
      it.node = NODE_W'(n);
      it.drain_first = drain_next;
      drain_next = 0;
      req_backlog.push_back(it);
      if (kind == REQ_APPEND && !plan_linked[n]) begin
         plan_linked[n] = 1;
         plan_owner[n] = q;
         plan_len[q]++;
      end else if (kind == REQ_REMOVE && plan_len[q] != 0 && plan_linked[n]
                   && plan_owner[n] == q) begin
         plan_linked[n] = 0;
         plan_len[q]--;
      end
   endfunction

   // Return a random node that is (or is not) linked, or -1 if there is none.
   function automatic int pick_node(bit want_linked);
      int start, n;
      start = $urandom_range(0, NODE_COUNT - 1);
      for (int i = 0; i < NODE_COUNT; i++) begin
         n = (start + i) % NODE_COUNT;
         if (plan_linked[n] == want_linked) return n;
      end
      return -1;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   // Driver: take words from the backlog, predict each one as it is taken.
   int gap_left;
   int tx_pct;
   req_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
         tx_pct <= 10;
         for (int i = 0; i < NODE_COUNT; i++) begin
            next_of[i] = '0;
            prev_of[i] = '0;
            in_use[i] = 1'b0;
            owner_of[i] = '0;
         end
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            head_of[i] = '0;
            filled[i] = 1'b0;
            length_of[i] = '0;
         end
      end else begin
         if ($urandom_range(0, 255) == 0) begin
            case ($urandom_range(0, 2))
               0: tx_pct <= 0;
               1: tx_pct <= 10;
               default: tx_pct <= 40;
            endcase
         end
         if (req_valid && !req_stall) begin
            pending_rsp.push_back(apply_to_queues(req_type, req_queue_id, req_node));
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0
                         && !(req_backlog[0].drain_first && pending_rsp.size() != 0)) begin
               next_item = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_type <= next_item.kind;
               req_queue_id <= next_item.qid;
               req_node <= next_item.node;
               if (req_backlog.size() > CALM_TAIL && $urandom_range(0, 99) < tx_pct) begin
                  gap_left <= $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold to fill the block.
   int stall_left;
   int hold_left;
   bit hold_done;
   int rx_pct;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 0;
         rx_pct <= 10;
      end else begin
         if ($urandom_range(0, 255) == 0) begin
            case ($urandom_range(0, 2))
               0: rx_pct <= 0;
               1: rx_pct <= 5;
               default: rx_pct <= 25;
            endcase
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && words_seen >= 250) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (words_seen + CALM_TAIL < total_items
                      && $urandom_range(0, 99) < rx_pct) begin
            stall_left <= $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: compare each response word with the oldest prediction.
   rsp_word_type got_word, want_word;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen <= words_seen + 1;
         got_word = '{rsp_status, rsp_queue_length, rsp_head_node, rsp_head_valid};
         if (pending_rsp.size() == 0) begin
            flag_mismatch($sformatf("unexpected word status=%0d length=%0d head=%0d/%0d",
                                    got_word.status, got_word.length, got_word.head,
                                    got_word.head_valid));
         end else begin
            want_word = pending_rsp.pop_front();
            if (got_word !== want_word) begin
               flag_mismatch($sformatf(
                  "status %0d/%0d length %0d/%0d head %0d/%0d head_valid %0d/%0d (exp/got)",
                  want_word.status, got_word.status, want_word.length, got_word.length,
                  want_word.head, got_word.head, want_word.head_valid, got_word.head_valid));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int n, q, r, focus_q;
      bit grow;
      mismatches = 0;
      words_seen = 0;
      drain_next = 0;
      grow = 1;
      focus_q = 0;
      for (int i = 0; i < NODE_COUNT; i++) begin
         plan_linked[i] = 0;
         plan_owner[i] = 0;
      end
      for (int i = 0; i < QUEUE_COUNT; i++) plan_len[i] = 0;

      // directed: every request kind and every refusal
      plan_request(REQ_SIZE, 0, 0);
      plan_request(REQ_REMOVE, 1, 5);     // empty queue
      plan_request(REQ_SPARE, 2, 63);
      plan_request(REQ_APPEND, 0, 0);
      plan_request(REQ_APPEND, 0, 63);
      plan_request(REQ_APPEND, 0, 21);
      plan_request(REQ_APPEND, 0, 33);
      plan_request(REQ_APPEND, 3, 42);
      plan_request(REQ_APPEND, 1, 0);     // already linked elsewhere
      plan_request(REQ_REMOVE, 0, 42);    // owned by another queue
      plan_request(REQ_REMOVE, 0, 7);     // isolated node
      plan_request(REQ_REMOVE, 0, 21);    // middle
      plan_request(REQ_REMOVE, 0, 0);     // head moves on
      plan_request(REQ_REMOVE, 0, 33);    // tail
      plan_request(REQ_REMOVE, 0, 63);    // last one out
      plan_request(REQ_SIZE, 0, 0);
      plan_request(REQ_REMOVE, 3, 42);
      plan_request(REQ_APPEND, 3, 63);
      plan_request(REQ_SIZE, 3, 0);
      plan_request(REQ_REMOVE, 3, 63);

      // fill one queue with the whole pool, then empty it in random order
      drain_next = 1;
      q = $urandom_range(0, QUEUE_COUNT - 1);
      for (n = pick_node(0); n >= 0; n = pick_node(0)) plan_request(REQ_APPEND, q, n);
      plan_request(REQ_SIZE, q, $urandom_range(0, NODE_COUNT - 1));
      for (n = pick_node(1); n >= 0; n = pick_node(1)) plan_request(REQ_REMOVE, q, n);

      // random phases, alternately growing and shrinking the queues
      while (req_backlog.size() < 900) begin
         if (req_backlog.size() % 100 == 0) begin
            grow = $urandom_range(0, 1);
            focus_q = $urandom_range(0, QUEUE_COUNT - 1);
         end
         if (req_backlog.size() == 500) drain_next = 1;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            plan_request($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 63));
         end else if (r < (grow ? 70 : 30)) begin
            n = pick_node(0);
            q = $urandom_range(0, 1) ? focus_q : $urandom_range(0, QUEUE_COUNT - 1);
            if (n < 0) plan_request(REQ_SIZE, q, $urandom_range(0, 63));
            else plan_request(REQ_APPEND, q, n);
         end else if (r < 92) begin
            n = pick_node(1);
            if (n < 0) plan_request(REQ_REMOVE, $urandom_range(0, 3), $urandom_range(0, 63));
            else plan_request(REQ_REMOVE, plan_owner[n], n);
         end else begin
            plan_request(REQ_SIZE, $urandom_range(0, 3), $urandom_range(0, 63));
         end
      end
      total_items = req_backlog.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/lqm_pkg.sv
rtl/core/lqm_ctrl.sv
rtl/core/lqm_datapath.sv
rtl/core/linked_queue_manager.sv
sim/testbench.sv
